// ===== hdl/cgse_pkg.sv =====
// Shared types and constants for the chi-square / gradient engine.
// No dependencies; cgse_if, the core and cgse_mac refer to this package.
package cgse_pkg;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 3;
  localparam int VAL_W      = 32;
  localparam int RES_W      = 64;
  localparam int MAX_OUT    = 8;
  localparam int DX_W       = VAL_W + 1;
  localparam int PROD_W     = 2 * DX_W;
  localparam int CHUNK_BITS = 32;
  localparam int CHUNK_W    = 2;

  localparam logic [RES_W-1:0] SAT_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] SAT_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_WEIGHT = 2'd0,
    OP_PARAM  = 2'd1,
    OP_POINT  = 2'd2,
    OP_RECALL = 2'd3
  } op_t;

  // Tag that travels with one multiply through the shared MAC.
  typedef struct packed {
    logic               vld;    // slot carries an operation
    logic               chi;    // chi partial product, else W*dx term
    logic               first;  // overwrite accumulator instead of adding
    logic               wvld;   // weight entry was written since reset
    logic [CHUNK_W-1:0] sh;     // chunk index of the row sum (chi only)
  } mac_tag_t;

endpackage

// ===== hdl/cgse_if.sv =====
// Valid/ready channel interfaces for input items and result beats.
// Depends on cgse_pkg for field widths.
interface cgse_in_if;
  logic                                valid;
  logic                                ready;
  logic [cgse_pkg::OP_W-1:0]           op;
  logic [cgse_pkg::IDX_W-1:0]          row_index;
  logic [cgse_pkg::IDX_W-1:0]          col_index;
  logic signed [cgse_pkg::VAL_W-1:0]   value;
  logic                                last;

  modport source(output valid, op, row_index, col_index, value, last, input ready);
  modport sink(input valid, op, row_index, col_index, value, last, output ready);
endinterface

interface cgse_out_if;
  logic                                valid;
  logic                                ready;
  logic [cgse_pkg::IDX_W-1:0]          grad_index;
  logic signed [cgse_pkg::RES_W-1:0]   grad_value;
  logic signed [cgse_pkg::RES_W-1:0]   chi_square;
  logic                                result_last;

  modport source(output valid, grad_index, grad_value, chi_square, result_last,
                 input ready);
  modport sink(input valid, grad_index, grad_value, chi_square, result_last,
               output ready);
endinterface

// ===== hdl/chi_square_gradient_engine_core.sv =====
// Chi-square / gradient engine top level. Uses cgse_pkg, cgse_if, cgse_ram, cgse_mac.
// Loads (op 0/1/2 without last) are taken whenever ready is high; ready drops only while busy.
// Evaluation: per row i, the W[i][j]*dx[j] terms, a gap, then the row-sum chunks times dx[i],
// all on the one shared MAC; then a drain, then min(NUM_PARAMS,8) result beats.
// Recall goes straight to the result beats. No new item is taken until the last beat.
// Synchronous active-high rst: W valid bits, x0, gradient cache and chi cleared at once.
module chi_square_gradient_engine_core #(
  parameter int NUM_PARAMS = 8,   // 1..16
  parameter int FRAC_BITS  = 16   // 0..24
) (
  input logic          clk,
  input logic          rst,
  cgse_in_if.sink      items,
  cgse_out_if.source   results
);

  // ---------------------------------------------------------------------------
  // Sizes derived from the parameters
  // ---------------------------------------------------------------------------
  localparam int N      = NUM_PARAMS;
  localparam int LOG_N  = $clog2(N);
  localparam int IW     = (N > 1) ? $clog2(N) : 1;
  localparam int WDEPTH = N * N;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int NOUT   = (N < cgse_pkg::MAX_OUT) ? N : cgse_pkg::MAX_OUT;
  localparam int OW     = (NOUT > 1) ? $clog2(NOUT) : 1;
  // Row sum: N products of 32x33 bits. Chi: N row sums times 33-bit dx.
  localparam int SW     = 65 + LOG_N;
  localparam int CW     = 97 + 2 * LOG_N;
  localparam int NCHUNK = (SW + cgse_pkg::CHUNK_BITS - 1) / cgse_pkg::CHUNK_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,    // take loads, recall and the final point element
    ST_MAC,     // one W[i][j]*dx[j] issue per cycle for row i
    ST_GAP,     // row sum settles in the accumulator
    ST_CHUNK,   // row sum times dx[i], one 32-bit chunk per cycle
    ST_DRAIN,   // wait for the last chi partial product
    ST_SEND     // result beats out of the cache
  } state_t;

  state_t                             state;
  logic [IW-1:0]                      row;        // i
  logic [IW-1:0]                      col;        // j
  logic [cgse_pkg::CHUNK_W-1:0]       chunk;      // k
  logic [WAW-1:0]                     rd_addr;    // i*N+j, counts up in row-major order
  logic [OW-1:0]                      beat;
  cgse_pkg::mac_tag_t                 tag1;
  cgse_pkg::mac_tag_t                 tag1_next;

  logic [WDEPTH-1:0]                  w_vld;
  logic signed [cgse_pkg::VAL_W-1:0]  params [N];
  logic signed [cgse_pkg::VAL_W-1:0]  point  [N];
  logic signed [cgse_pkg::RES_W-1:0]  cache  [NOUT];
  logic signed [cgse_pkg::RES_W-1:0]  cached_chi;
  logic signed [cgse_pkg::DX_W-1:0]   dx1;
  logic signed [cgse_pkg::DX_W-1:0]   dx_next;
  logic [IW-1:0]                      dx_idx;

  logic                               acc_in;
  cgse_pkg::op_t                      in_op;
  logic                               row_ok;
  logic                               col_ok;
  logic [IW-1:0]                      ld_idx;
  logic                               w_we;
  logic [WAW-1:0]                     w_waddr;
  logic                               start_eval;
  logic                               start_recall;
  logic [cgse_pkg::VAL_W-1:0]         w_rdata;
  logic                               dp_busy;
  logic signed [cgse_pkg::RES_W-1:0]  grad_sat;
  logic signed [cgse_pkg::RES_W-1:0]  chi_sat;
  logic                               row_done;
  logic                               chunk_done;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  assign items.ready  = (state == ST_IDLE);
  assign acc_in       = items.valid && items.ready;
  assign in_op        = cgse_pkg::op_t'(items.op);
  assign row_ok       = int'(items.row_index) < N;
  assign col_ok       = int'(items.col_index) < N;
  assign ld_idx       = IW'(items.row_index);
  assign w_waddr      = WAW'(int'(items.row_index) * N + int'(items.col_index));
  assign w_we         = acc_in && (in_op == cgse_pkg::OP_WEIGHT) && row_ok && col_ok;
  // The final point element starts a run even if its own index is out of range.
  assign start_eval   = acc_in && (in_op == cgse_pkg::OP_POINT) && items.last;
  assign start_recall = acc_in && (in_op == cgse_pkg::OP_RECALL);

  assign row_done     = (col == IW'(N - 1));
  assign chunk_done   = (chunk == cgse_pkg::CHUNK_W'(NCHUNK - 1));

  // ---------------------------------------------------------------------------
  // Weight matrix: RAM plus one valid bit per entry, so a never-written entry
  // reads as zero without a clearing pass.
  // ---------------------------------------------------------------------------
  cgse_ram #(
    .WIDTH (cgse_pkg::VAL_W),
    .DEPTH (WDEPTH)
  ) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (items.value),
    .raddr (rd_addr),
    .rdata (w_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      w_vld <= '0;
    end else if (w_we) begin
      w_vld[w_waddr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Vectors and result cache
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < N; n++) begin
        params[n] <= '0;
      end
      for (int n = 0; n < NOUT; n++) begin
        cache[n] <= '0;
      end
      cached_chi <= '0;
    end else begin
      if (acc_in && (in_op == cgse_pkg::OP_PARAM) && row_ok) begin
        params[ld_idx] <= items.value;
      end
      // Row sum is final by the last chunk issue of that row.
      if ((state == ST_CHUNK) && chunk_done && (int'(row) < NOUT)) begin
        cache[OW'(row)] <= grad_sat;
      end
      if ((state == ST_DRAIN) && !tag1.vld && !dp_busy) begin
        cached_chi <= chi_sat;
      end
    end
  end

  // Current point has no reset; a never-written element is outside the contract.
  always_ff @(posedge clk) begin
    if (acc_in && (in_op == cgse_pkg::OP_POINT) && row_ok) begin
      point[ld_idx] <= items.value;
    end
  end

  // dx for the issuing slot: dx[j] for MAC terms, dx[i] for chi chunks.
  assign dx_idx  = (state == ST_CHUNK) ? row : col;
  assign dx_next = cgse_pkg::DX_W'(point[dx_idx]) - cgse_pkg::DX_W'(params[dx_idx]);

  always_ff @(posedge clk) begin
    dx1 <= dx_next;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: state plus the issue-stage tag that lines up with RAM read data
  // ---------------------------------------------------------------------------
  // Tag for the slot issued this cycle; empty outside the MAC and chunk phases.
  always_comb begin
    tag1_next = '0;
    case (state)
      ST_MAC: begin
        tag1_next.vld   = 1'b1;
        tag1_next.first = (col == '0);
        tag1_next.wvld  = w_vld[rd_addr];
      end
      ST_CHUNK: begin
        tag1_next.vld   = 1'b1;
        tag1_next.chi   = 1'b1;
        tag1_next.first = (row == '0) && (chunk == '0);
        tag1_next.sh    = chunk;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row     <= '0;
      col     <= '0;
      chunk   <= '0;
      rd_addr <= '0;
      beat    <= '0;
      tag1    <= '0;
    end else begin
      tag1 <= tag1_next;
      case (state)
        ST_IDLE: begin
          if (start_eval) begin
            state   <= ST_MAC;
            row     <= '0;
            col     <= '0;
            chunk   <= '0;
            rd_addr <= '0;
          end else if (start_recall) begin
            state <= ST_SEND;
            beat  <= '0;
          end
        end
        ST_MAC: begin
          rd_addr <= rd_addr + 1'b1;
          if (row_done) begin
            col   <= '0;
            state <= ST_GAP;
          end else begin
            col <= col + 1'b1;
          end
        end
        ST_GAP: begin
          chunk <= '0;
          state <= ST_CHUNK;
        end
        ST_CHUNK: begin
          if (chunk_done) begin
            chunk <= '0;
            if (row == IW'(N - 1)) begin
              state <= ST_DRAIN;
            end else begin
              row   <= row + 1'b1;
              state <= ST_MAC;
            end
          end else begin
            chunk <= chunk + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!tag1.vld && !dp_busy) begin
            beat  <= '0;
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (results.ready) begin
            if (results.result_last) begin
              state <= ST_IDLE;
            end else begin
              beat <= beat + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared MAC: multiply, then accumulate into the row sum or chi
  // ---------------------------------------------------------------------------
  cgse_mac #(
    .SUM_W      (SW),
    .CHI_W      (CW),
    .FRAC_BITS  (FRAC_BITS),
    .NUM_CHUNKS (NCHUNK)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .tag      (tag1),
    .w_data   (w_rdata),
    .dx       (dx1),
    .busy     (dp_busy),
    .grad_sat (grad_sat),
    .chi_sat  (chi_sat)
  );

  // ---------------------------------------------------------------------------
  // Result beats straight from the cache; chi rides on the final beat only.
  // ---------------------------------------------------------------------------
  assign results.valid       = (state == ST_SEND);
  assign results.grad_index  = cgse_pkg::IDX_W'(beat);
  assign results.grad_value  = cache[beat];
  assign results.result_last = (beat == OW'(NOUT - 1));
  assign results.chi_square  = results.result_last ? cached_chi : '0;

`ifndef SYNTHESIS
  // The MAC pipeline must be empty before the cache is shown.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND) |-> (!tag1.vld && !dp_busy))
    else $error("result beat while MAC pipeline still busy");

  // The final point element starts a MAC pass on the next cycle.
  a_start: assert property (@(posedge clk) disable iff (rst)
    start_eval |=> (state == ST_MAC))
    else $error("evaluation did not start");

  // After the final beat the block takes items again.
  a_done: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && results.result_last) |=> items.ready)
    else $error("block not idle after final beat");

  // Chi partial products only issue in the chunk phase.
  a_chi_issue: assert property (@(posedge clk) disable iff (rst)
    (tag1.vld && tag1.chi) |-> ($past(state) == ST_CHUNK))
    else $error("chi partial product outside chunk phase");
`endif

endmodule

// ===== hdl/cgse_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cgse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cgse_mac.sv =====
// Shared signed 33x33 multiplier with row-sum and chi accumulators, plus
// output saturation. Depends on cgse_pkg (mac_tag_t, widths, limits).
module cgse_mac #(
  parameter int SUM_W      = 68,
  parameter int CHI_W      = 103,
  parameter int FRAC_BITS  = 16,
  parameter int NUM_CHUNKS = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cgse_pkg::mac_tag_t                  tag,
  input  logic signed [cgse_pkg::VAL_W-1:0]   w_data,
  input  logic signed [cgse_pkg::DX_W-1:0]    dx,
  output logic                                busy,
  output logic signed [cgse_pkg::RES_W-1:0]   grad_sat,
  output logic signed [cgse_pkg::RES_W-1:0]   chi_sat
);

  localparam int EXT_W = NUM_CHUNKS * cgse_pkg::CHUNK_BITS;

  cgse_pkg::mac_tag_t                   tag_q;
  logic signed [cgse_pkg::PROD_W-1:0]   prod;
  logic signed [cgse_pkg::DX_W-1:0]     a_op;
  logic signed [SUM_W-1:0]              s_acc;
  logic signed [CHI_W-1:0]              chi_acc;
  logic signed [EXT_W-1:0]              s_ext;
  logic signed [CHI_W-1:0]              pp_ext;
  logic signed [CHI_W-1:0]              pp_shift;
  logic signed [SUM_W:0]                two_s;
  logic signed [CHI_W-1:0]              chi_sh;

  // Operand A: weight entry, or one 32-bit chunk of the row sum
  // (lower chunks unsigned, top chunk signed).
  always_comb begin
    s_ext = EXT_W'(s_acc);
    a_op  = '0;
    if (tag.chi) begin
      for (int c = 0; c < NUM_CHUNKS; c++) begin
        if (tag.sh == cgse_pkg::CHUNK_W'(c)) begin
          a_op = {(c == NUM_CHUNKS - 1) ? s_ext[c*cgse_pkg::CHUNK_BITS + 31] : 1'b0,
                  s_ext[c*cgse_pkg::CHUNK_BITS +: cgse_pkg::CHUNK_BITS]};
        end
      end
    end else if (tag.wvld) begin
      a_op = cgse_pkg::DX_W'(w_data);
    end
  end

  always_comb begin
    pp_ext   = CHI_W'(prod);
    pp_shift = pp_ext;
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      if (tag_q.sh == cgse_pkg::CHUNK_W'(c)) begin
        pp_shift = pp_ext << (c * cgse_pkg::CHUNK_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_op * dx;
    if (tag_q.vld) begin
      if (tag_q.chi) begin
        chi_acc <= tag_q.first ? pp_shift : chi_acc + pp_shift;
      end else begin
        s_acc <= tag_q.first ? SUM_W'(prod) : s_acc + SUM_W'(prod);
      end
    end
  end

  assign busy   = tag_q.vld;
  assign two_s  = {s_acc, 1'b0};
  assign chi_sh = chi_acc >>> FRAC_BITS;

  always_comb begin
    if ((&two_s[SUM_W:cgse_pkg::RES_W-1]) || !(|two_s[SUM_W:cgse_pkg::RES_W-1])) begin
      grad_sat = two_s[cgse_pkg::RES_W-1:0];
    end else begin
      grad_sat = two_s[SUM_W] ? cgse_pkg::SAT_MIN : cgse_pkg::SAT_MAX;
    end
    if ((&chi_sh[CHI_W-1:cgse_pkg::RES_W-1]) || !(|chi_sh[CHI_W-1:cgse_pkg::RES_W-1])) begin
      chi_sat = chi_sh[cgse_pkg::RES_W-1:0];
    end else begin
      chi_sat = chi_sh[CHI_W-1] ? cgse_pkg::SAT_MIN : cgse_pkg::SAT_MAX;
    end
  end

endmodule
